// ===== hw/rtl/ascf_pkg.sv =====
// Shared types, constants and helper functions for the coordinate frame parser.
// No dependencies; used by ascf_parser and ascii_coordinate_frame_parser_core.
package ascf_pkg;

    localparam int BUF_BYTES = 32;
    localparam int CNT_W = $clog2(BUF_BYTES);

    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_MINUS  = 8'd45;

    localparam int MAG_CAP = 32768;
    localparam int MARKER_W = 15;
    localparam logic [MARKER_W-1:0] LOST_MARKER_RESET = 15'd9999;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_XPRE  = 8'b0000_0010,
        PH_XSIGN = 8'b0000_0100,
        PH_XDIG  = 8'b0000_1000,
        PH_YPRE  = 8'b0001_0000,
        PH_YSIGN = 8'b0010_0000,
        PH_YDIG  = 8'b0100_0000,
        PH_TAIL  = 8'b1000_0000
    } ascf_phase_t;

    typedef struct packed {
        logic signed [15:0] x_error;
        logic signed [15:0] y_error;
        logic               target_lost;
    } ascf_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    // mag * 10 + digit, clamped at the cap
    function automatic logic [15:0] acc_digit(input logic [15:0] mag, input logic [7:0] c);
        logic [19:0] m;
        m = 20'({mag, 3'b000}) + 20'({mag, 1'b0}) + 20'(c[3:0]);
        return (m > 20'(MAG_CAP)) ? 16'(MAG_CAP) : m[15:0];
    endfunction

    // Sign and clamp to 16-bit signed; magnitude never exceeds the cap
    function automatic logic signed [15:0] signed_value(input logic neg,
                                                        input logic [15:0] mag);
        logic [15:0] pos;
        pos = (mag > 16'd32767) ? 16'd32767 : mag;
        return neg ? $signed(16'(~mag + 16'd1)) : $signed(pos);
    endfunction

endpackage

// ===== hw/rtl/ascf_parser.sv =====
// Frame grammar state machine and number accumulators for the frame parser.
// Depends on ascf_pkg; one byte is consumed per cycle when step_en is high.
module ascf_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [7:0]                    rx_byte,
    input  logic [ascf_pkg::MARKER_W-1:0] lost_marker,
    output logic                          res_valid,
    output ascf_pkg::ascf_result_t        res
);

    ascf_pkg::ascf_phase_t          phase_reg, phase_next;
    logic [ascf_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           x_neg_reg, x_neg_next;
    logic [15:0]                    x_mag_reg, x_mag_next;
    logic                           y_neg_reg, y_neg_next;
    logic [15:0]                    y_mag_reg, y_mag_next;

    logic signed [15:0] xv;
    logic signed [15:0] yv;
    logic               lost;

    assign xv   = ascf_pkg::signed_value(x_neg_reg, x_mag_reg);
    assign yv   = ascf_pkg::signed_value(y_neg_reg, y_mag_reg);
    assign lost = (xv == $signed({1'b0, lost_marker}))
               && (yv == $signed({1'b0, lost_marker}));

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        x_neg_next = x_neg_reg;
        x_mag_next = x_mag_reg;
        y_neg_next = y_neg_reg;
        y_mag_next = y_mag_reg;
        res_valid  = 1'b0;
        res.x_error     = lost ? 16'sd0 : xv;
        res.y_error     = lost ? 16'sd0 : yv;
        res.target_lost = lost;

        if (rx_byte == ascf_pkg::CH_DOLLAR) begin
            // a start byte always opens a fresh frame
            phase_next = ascf_pkg::PH_XPRE;
            count_next = ascf_pkg::CNT_W'(1);
            x_neg_next = 1'b0;
            x_mag_next = '0;
            y_neg_next = 1'b0;
            y_mag_next = '0;
        end else if (phase_reg == ascf_pkg::PH_IDLE) begin
            // drop bytes outside a frame
        end else if (count_reg >= ascf_pkg::CNT_W'(ascf_pkg::BUF_BYTES - 1)) begin
            phase_next = ascf_pkg::PH_IDLE;
            count_next = '0;
        end else if (rx_byte == ascf_pkg::CH_HASH) begin
            phase_next = ascf_pkg::PH_IDLE;
            count_next = '0;
            res_valid  = (phase_reg == ascf_pkg::PH_YDIG) || (phase_reg == ascf_pkg::PH_TAIL);
        end else begin
            count_next = count_reg + 1'b1;
            case (phase_reg)
                ascf_pkg::PH_XPRE: begin
                    if (ascf_pkg::is_space(rx_byte)) begin
                    end else if (rx_byte == ascf_pkg::CH_PLUS || rx_byte == ascf_pkg::CH_MINUS) begin
                        x_neg_next = (rx_byte == ascf_pkg::CH_MINUS);
                        phase_next = ascf_pkg::PH_XSIGN;
                    end else if (ascf_pkg::is_digit(rx_byte)) begin
                        x_mag_next = ascf_pkg::acc_digit(x_mag_reg, rx_byte);
                        phase_next = ascf_pkg::PH_XDIG;
                    end else begin
                        phase_next = ascf_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
                ascf_pkg::PH_XSIGN: begin
                    if (ascf_pkg::is_digit(rx_byte)) begin
                        x_mag_next = ascf_pkg::acc_digit(x_mag_reg, rx_byte);
                        phase_next = ascf_pkg::PH_XDIG;
                    end else begin
                        phase_next = ascf_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
                ascf_pkg::PH_XDIG: begin
                    if (ascf_pkg::is_digit(rx_byte)) begin
                        x_mag_next = ascf_pkg::acc_digit(x_mag_reg, rx_byte);
                    end else if (rx_byte == ascf_pkg::CH_COMMA) begin
                        phase_next = ascf_pkg::PH_YPRE;
                    end else begin
                        phase_next = ascf_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
                ascf_pkg::PH_YPRE: begin
                    if (ascf_pkg::is_space(rx_byte)) begin
                    end else if (rx_byte == ascf_pkg::CH_PLUS || rx_byte == ascf_pkg::CH_MINUS) begin
                        y_neg_next = (rx_byte == ascf_pkg::CH_MINUS);
                        phase_next = ascf_pkg::PH_YSIGN;
                    end else if (ascf_pkg::is_digit(rx_byte)) begin
                        y_mag_next = ascf_pkg::acc_digit(y_mag_reg, rx_byte);
                        phase_next = ascf_pkg::PH_YDIG;
                    end else begin
                        phase_next = ascf_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
                ascf_pkg::PH_YSIGN: begin
                    if (ascf_pkg::is_digit(rx_byte)) begin
                        y_mag_next = ascf_pkg::acc_digit(y_mag_reg, rx_byte);
                        phase_next = ascf_pkg::PH_YDIG;
                    end else begin
                        phase_next = ascf_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
                ascf_pkg::PH_YDIG: begin
                    if (ascf_pkg::is_digit(rx_byte)) begin
                        y_mag_next = ascf_pkg::acc_digit(y_mag_reg, rx_byte);
                    end else begin
                        phase_next = ascf_pkg::PH_TAIL;
                    end
                end
                ascf_pkg::PH_TAIL: begin
                    // ignore everything up to the end byte
                end
                default: begin
                    phase_next = ascf_pkg::PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ascf_pkg::PH_IDLE;
            count_reg <= '0;
            x_neg_reg <= 1'b0;
            x_mag_reg <= '0;
            y_neg_reg <= 1'b0;
            y_mag_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            x_neg_reg <= x_neg_next;
            x_mag_reg <= x_mag_next;
            y_neg_reg <= y_neg_next;
            y_mag_reg <= y_mag_next;
        end
    end

endmodule

// ===== hw/rtl/ascii_coordinate_frame_parser_core.sv =====
// Top level of the ASCII coordinate frame parser: input register, parser, result register.
// Depends on ascf_pkg and ascf_parser.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry one received byte per request. Frames look like
//   "$x,y#"; each complete frame yields one request on m_valid/m_ready with
//   m_x_error, m_y_error and m_target_lost. Bytes outside a frame, malformed
//   frames and frames that fill the buffer or run longer produce nothing.
//   cfg_we/cfg_wdata write the lost marker (reset 9999); write it only while idle.
// Result path: the closing '#' is accepted into the input register and waits there until the
//   parser can step; the parser then loads the result register, which raises m_valid.
// Throughput: one byte per cycle while m_ready is high; the limit is the single
//   parser state update per cycle between the input and result registers.
// Stall: when m_ready is low with a result waiting, the byte in the input register
//   holds and s_ready drops once that register is full; no byte is lost.
// Reset: aresetn low clears the valid bits of both registers, the parser returns to idle
//   outside any frame and the lost marker returns to 9999.
module ascii_coordinate_frame_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_x_error,
    output logic signed [15:0]            m_y_error,
    output logic                          m_target_lost,
    input  logic                          cfg_we,
    input  logic [ascf_pkg::MARKER_W-1:0] cfg_wdata
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg;
    ascf_pkg::ascf_result_t        out_reg;
    logic [ascf_pkg::MARKER_W-1:0] marker_reg;

    logic                   step_en;
    logic                   res_valid;
    ascf_pkg::ascf_result_t res;

    // advance a byte only when the result slot is free or being drained
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    ascf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .rx_byte     (in_byte_reg),
        .lost_marker (marker_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= ascf_pkg::LOST_MARKER_RESET;
        end else if (cfg_we) begin
            marker_reg <= cfg_wdata;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_x_error     = out_reg.x_error;
    assign m_y_error     = out_reg.y_error;
    assign m_target_lost = out_reg.target_lost;

    // a result is only produced by the closing byte of a frame
    a_res_on_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res_valid) |-> (in_byte_reg == ascf_pkg::CH_HASH))
        else $error("result raised on a byte other than the end marker");

    // a lost target always reports zero errors
    a_lost_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target_lost) |-> (m_x_error == 16'sd0 && m_y_error == 16'sd0))
        else $error("lost target with nonzero errors");

    // backpressure only while a byte is held
    a_ready_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a held byte and a blocked result");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== verif/ascii_coordinate_frame_parser_core_tb.sv =====
// Self-checking testbench for ascii_coordinate_frame_parser_core: byte frames in, coordinates out.
// Depends on ascf_pkg (types, characters, BUF_BYTES) and the core RTL; keeps its own parser model.
module ascii_coordinate_frame_parser_core_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_NUL   = 8'd0;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_rx_byte;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [15:0]            m_x_error;
    logic signed [15:0]            m_y_error;
    logic                          m_target_lost;
    logic                          cfg_we;
    logic [ascf_pkg::MARKER_W-1:0] cfg_wdata;

    ascii_coordinate_frame_parser_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_error     (m_x_error),
        .m_y_error     (m_y_error),
        .m_target_lost (m_target_lost),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // parser model state
    ascf_pkg::ascf_phase_t         frame_phase;
    int unsigned                   frame_len;
    logic                          x_neg;
    logic                          y_neg;
    logic [15:0]                   x_mag;
    logic [15:0]                   y_mag;
    logic [ascf_pkg::MARKER_W-1:0] lost_marker_model;

    ascf_pkg::ascf_result_t        pending_coords[$];
    logic [7:0]                    tx_bytes[$];

    int mismatches         = 0;
    int bytes_sent         = 0;
    int coords_checked     = 0;
    int lost_seen          = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_coords.size());
            $display("ascii_coordinate_frame_parser_core test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        ascf_pkg::ascf_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_coords.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d lost=%0b",
                                          m_x_error, m_y_error, m_target_lost));
            end else begin
                want = pending_coords.pop_front();
                if (m_x_error !== want.x_error)
                    report_mismatch($sformatf("x_error got %0d want %0d",
                                              m_x_error, want.x_error));
                if (m_y_error !== want.y_error)
                    report_mismatch($sformatf("y_error got %0d want %0d",
                                              m_y_error, want.y_error));
                if (m_target_lost !== want.target_lost)
                    report_mismatch($sformatf("target_lost got %0b want %0b",
                                              m_target_lost, want.target_lost));
                coords_checked++;
                if (want.target_lost)
                    lost_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- model

    function automatic bit ws_byte(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [15:0] push_digit(input logic [15:0] mag, input logic [7:0] c);
        int unsigned m;
        m = 32'(mag) * 10 + 32'(c) - 32'(CH_ZERO);
        return (m > 32768) ? 16'd32768 : m[15:0];
    endfunction

    function automatic int clamp_coord(input logic neg, input logic [15:0] mag);
        int m;
        m = int'(mag);
        if (neg)
            return (m > 32768) ? -32768 : -m;
        return (m > 32767) ? 32767 : m;
    endfunction

    function automatic void leave_frame();
        frame_phase = ascf_pkg::PH_IDLE;
        frame_len   = 0;
    endfunction

    // advance the parser model by one accepted byte; queue a result on a closed frame
    function automatic void parse_byte(input logic [7:0] c);
        ascf_pkg::ascf_result_t res;
        int xv;
        int yv;
        bit complete;
        if (c == ascf_pkg::CH_DOLLAR) begin
            frame_phase = ascf_pkg::PH_XPRE;
            frame_len   = 1;
            x_neg = 1'b0;
            x_mag = '0;
            y_neg = 1'b0;
            y_mag = '0;
            return;
        end
        if (frame_phase == ascf_pkg::PH_IDLE)
            return;
        if (frame_len >= ascf_pkg::BUF_BYTES - 1) begin
            leave_frame();
            return;
        end
        frame_len++;
        if (c == ascf_pkg::CH_HASH) begin
            complete = (frame_phase == ascf_pkg::PH_YDIG)
                    || (frame_phase == ascf_pkg::PH_TAIL);
            leave_frame();
            if (complete) begin
                xv = clamp_coord(x_neg, x_mag);
                yv = clamp_coord(y_neg, y_mag);
                if (xv == int'(lost_marker_model) && yv == int'(lost_marker_model)) begin
                    res.x_error     = '0;
                    res.y_error     = '0;
                    res.target_lost = 1'b1;
                end else begin
                    res.x_error     = 16'(xv);
                    res.y_error     = 16'(yv);
                    res.target_lost = 1'b0;
                end
                pending_coords.push_back(res);
            end
            return;
        end
        case (frame_phase)
            ascf_pkg::PH_XPRE: begin
                if (c == ascf_pkg::CH_PLUS || c == ascf_pkg::CH_MINUS) begin
                    x_neg = (c == ascf_pkg::CH_MINUS);
                    frame_phase = ascf_pkg::PH_XSIGN;
                end else if (digit_byte(c)) begin
                    x_mag = push_digit(x_mag, c);
                    frame_phase = ascf_pkg::PH_XDIG;
                end else if (!ws_byte(c)) begin
                    leave_frame();
                end
            end
            ascf_pkg::PH_XSIGN: begin
                if (digit_byte(c)) begin
                    x_mag = push_digit(x_mag, c);
                    frame_phase = ascf_pkg::PH_XDIG;
                end else begin
                    leave_frame();
                end
            end
            ascf_pkg::PH_XDIG: begin
                if (digit_byte(c))
                    x_mag = push_digit(x_mag, c);
                else if (c == ascf_pkg::CH_COMMA)
                    frame_phase = ascf_pkg::PH_YPRE;
                else
                    leave_frame();
            end
            ascf_pkg::PH_YPRE: begin
                if (c == ascf_pkg::CH_PLUS || c == ascf_pkg::CH_MINUS) begin
                    y_neg = (c == ascf_pkg::CH_MINUS);
                    frame_phase = ascf_pkg::PH_YSIGN;
                end else if (digit_byte(c)) begin
                    y_mag = push_digit(y_mag, c);
                    frame_phase = ascf_pkg::PH_YDIG;
                end else if (!ws_byte(c)) begin
                    leave_frame();
                end
            end
            ascf_pkg::PH_YSIGN: begin
                if (digit_byte(c)) begin
                    y_mag = push_digit(y_mag, c);
                    frame_phase = ascf_pkg::PH_YDIG;
                end else begin
                    leave_frame();
                end
            end
            ascf_pkg::PH_YDIG: begin
                if (digit_byte(c))
                    y_mag = push_digit(y_mag, c);
                else
                    frame_phase = ascf_pkg::PH_TAIL;
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- driving

    // called at a falling edge; returns at the falling edge after the request
    task automatic send_one(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid   = 1'b0;
            s_rx_byte = 8'($urandom);
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        parse_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_queued();
        foreach (tx_bytes[i])
            send_one(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            tx_bytes.push_back(s[i]);
    endtask

    // drop valid and hold off until every expected result has come out
    task automatic wait_for_drain();
        s_valid = 1'b0;
        while (pending_coords.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_lost_marker(input logic [ascf_pkg::MARKER_W-1:0] value);
        wait_for_drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        lost_marker_model = value;
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == ascf_pkg::CH_DOLLAR || b == ascf_pkg::CH_HASH);
        return b;
    endfunction

    task automatic add_coord(input bit marker_form);
        int    kind;
        bit    neg;
        string digits;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2))
                add_byte($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        kind = marker_form ? 3 : $urandom_range(2);
        neg  = (kind != 3 || lost_marker_model == 0) && ($urandom_range(2) == 0);
        case (kind)
            0: digits = $sformatf("%0d", $urandom_range(99));
            1: digits = $sformatf("%0d", $urandom_range(32768));
            2: digits = $sformatf("%0d%0d", $urandom_range(10000, 99999), $urandom_range(9999));
            default: digits = $sformatf("%0d", lost_marker_model);
        endcase
        if (neg)
            add_byte(ascf_pkg::CH_MINUS);
        else if ($urandom_range(4) == 0)
            add_byte(ascf_pkg::CH_PLUS);
        if ($urandom_range(7) == 0)
            add_byte(CH_ZERO);
        add_text(digits);
    endtask

    // mostly well-formed frames; some padded to the length limit, some corrupted
    task automatic add_frame();
        int first;
        int tail_len;
        int pick;
        bit lost_pair;
        lost_pair = ($urandom_range(4) == 0);
        first = tx_bytes.size();
        add_byte(ascf_pkg::CH_DOLLAR);
        add_coord(lost_pair);
        add_byte(ascf_pkg::CH_COMMA);
        add_coord(lost_pair);
        if ($urandom_range(7) == 0)
            tail_len = 28 + $urandom_range(4) - (tx_bytes.size() - first);
        else
            tail_len = $urandom_range(1) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < tail_len; i++)
            add_byte((i == 0 && $urandom_range(3) == 0) ? CH_NUL : junk_byte());
        add_byte(ascf_pkg::CH_HASH);
        pick = $urandom_range(5);
        if (pick == 0)
            tx_bytes[first + $urandom_range(1, tx_bytes.size() - first - 1)] = 8'($urandom);
        else if (pick == 1)
            tx_bytes.delete(first + $urandom_range(1, tx_bytes.size() - first - 1));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_basic_frames();
        add_text("$12,-34#");
        add_text("$ +7,\t0 tail#");
        add_text("$-32768,32767#");
        add_text("$5,6");
        add_byte(CH_NUL);
        add_text("#");
        send_queued();
    endtask

    task automatic test_lost_marker_frames();
        add_text($sformatf("$%0d,%0d#", lost_marker_model, lost_marker_model));
        add_text($sformatf("$%0d,%0d#", lost_marker_model, lost_marker_model ^ 15'd1));
        add_text($sformatf("$-%0d,+%0d#", lost_marker_model, lost_marker_model));
        add_text("$99999,99999#");
        send_queued();
    endtask

    task automatic test_saturation();
        add_text("$99999,-99999#");
        add_text("$-32769,032768#");
        add_text("$-32768,-0#");
        send_queued();
    endtask

    task automatic test_malformed();
        add_text("ab#");
        add_text("$1 ,2#");
        add_text("$,1#");
        add_text("$+,1#");
        add_text("$1,-#");
        add_text("$1");
        add_byte(CH_NUL);
        add_text(",2#");
        add_text("$3,");
        add_byte(8'hFF);
        add_text("4#");
        // a second start byte restarts the frame
        add_text("$1,$3,4#");
        send_queued();
    endtask

    task automatic test_frame_overflow();
        // closing byte lands just below the limit, then exactly on it
        for (int pad = 26; pad <= 27; pad++) begin
            add_text("$1,2");
            repeat (pad) add_byte(CH_SPACE);
            add_text("#");
        end
        // overflow on the first digit after the leading whitespace, then recover
        add_byte(ascf_pkg::CH_DOLLAR);
        repeat (30) add_byte(CH_SPACE);
        add_text("12,3#$4,5#");
        send_queued();
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n_bytes);
        int sent;
        int frames;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent   = 0;
        frames = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
                send_queued();
            end
            add_frame();
            sent += tx_bytes.size();
            send_queued();
            frames++;
            if (frames % 30 == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        frame_phase = ascf_pkg::PH_IDLE;
        frame_len   = 0;
        x_neg = 1'b0;
        x_mag = '0;
        y_neg = 1'b0;
        y_mag = '0;
        lost_marker_model = ascf_pkg::LOST_MARKER_RESET;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_basic_frames();
        test_lost_marker_frames();
        test_saturation();
        test_malformed();
        test_frame_overflow();
        test_random_stream(0, 0, 280);

        write_lost_marker('0);
        test_lost_marker_frames();
        test_random_stream(53, 0, 280);

        write_lost_marker('1);
        test_lost_marker_frames();
        test_random_stream(0, 53, 280);

        write_lost_marker(ascf_pkg::MARKER_W'($urandom));
        test_lost_marker_frames();
        test_random_stream(23, 23, 280);

        wait_for_drain();
        $display("Sent %0d bytes over four idle/stall mixes and four lost-marker values;",
                 bytes_sent);
        $display("checked %0d coordinate results, %0d of them target lost, %0d mismatches.",
                 coords_checked, lost_seen, mismatches);
        if (mismatches == 0 && pending_coords.size() == 0) begin
            $display("ascii_coordinate_frame_parser_core test passed");
        end else begin
            $display("ascii_coordinate_frame_parser_core test failed");
        end
        $finish;
    end

endmodule
